/* hdl/wsfp_pkg.sv */
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

	localparam int unsigned LenW = 17;

	localparam logic [LenW-1:0] LenSat     = {LenW{1'b1}};
	localparam logic [LenW-1:0] MaxPayRst  = 17'd65536;
	localparam logic [6:0]      Len7Ext16  = 7'd126;
	localparam logic [6:0]      Len7Ext64  = 7'd127;
	localparam logic [2:0]      Ext16Last  = 3'd1;
	localparam logic [2:0]      Ext64Last  = 3'd7;
	localparam logic [2:0]      KeyLast    = 3'd3;

	typedef enum logic [2:0] {
		ST_DATA       = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_INCOMPLETE = 3'd2,
		ST_UNMASKED   = 3'd3,
		ST_TOO_LARGE  = 3'd4
	} wsfp_status_t;

	typedef struct packed {
		wsfp_status_t    status;
		logic [7:0]      payload_byte;
		logic            last_of_payload;
		logic [LenW-1:0] decoded_length;
		logic [3:0]      frame_opcode;
		logic            final_fragment;
	} wsfp_result_t;

endpackage

/* hdl/wsfp_core.sv */
// ----------------------------------------------------------------------------
// wsfp_core
// Frame parsing state and per-byte result logic for one registered byte.
// ----------------------------------------------------------------------------
module wsfp_core
	import wsfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	input  logic [LenW-1:0]    max_payload,
	output logic               res_valid,
	output wsfp_result_t       res
);

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_KEY   = 3'd4,
		PH_DATA  = 3'd5,
		PH_SKIP  = 3'd6
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [2:0]      hcnt_q, hcnt_d;
	logic [LenW-1:0] len_q, len_d;
	logic            over_q, over_d;
	logic [31:0]     key_q, key_d;
	logic [LenW-1:0] rem_q, rem_d;
	logic [1:0]      kidx_q, kidx_d;
	logic [3:0]      opc_q, opc_d;
	logic            fin_q, fin_d;

	logic            gen;
	wsfp_status_t    st;
	logic [7:0]      pbyte;
	logic            plast;
	logic            ext_sat;
	logic [LenW-1:0] ext_len;
	logic            judge_bad;
	logic [7:0]      key_byte;

	// The shifted accumulator overflows when any of its top bits would leave 17 bits.
	assign ext_sat = |len_q[LenW-1:LenW-8];
	assign ext_len = ext_sat ? LenSat : {len_q[LenW-9:0], data_byte};

	always_comb begin
		unique case (kidx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		hcnt_d    = hcnt_q;
		len_d     = len_q;
		over_d    = over_q;
		key_d     = key_q;
		rem_d     = rem_q;
		kidx_d    = kidx_q;
		opc_d     = opc_q;
		fin_d     = fin_q;
		gen       = 1'b0;
		st        = ST_DATA;
		pbyte     = 8'd0;
		plast     = 1'b0;
		judge_bad = 1'b0;

		unique case (phase_q)
			PH_HDR0: begin
				fin_d   = data_byte[7];
				opc_d   = data_byte[3:0];
				len_d   = '0;
				over_d  = 1'b0;
				hcnt_d  = '0;
				key_d   = '0;
				kidx_d  = '0;
				rem_d   = '0;
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				if (!data_byte[7]) begin
					gen     = 1'b1;
					st      = ST_UNMASKED;
					phase_d = PH_SKIP;
				end else begin
					hcnt_d = '0;
					if (data_byte[6:0] == Len7Ext16) begin
						phase_d = PH_EXT16;
					end else if (data_byte[6:0] == Len7Ext64) begin
						phase_d = PH_EXT64;
					end else begin
						len_d     = {{(LenW-7){1'b0}}, data_byte[6:0]};
						judge_bad = over_q || (len_d > max_payload);
						if (judge_bad) begin
							gen     = 1'b1;
							st      = ST_TOO_LARGE;
							phase_d = PH_SKIP;
						end else begin
							phase_d = PH_KEY;
						end
					end
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_d  = ext_len;
				over_d = over_q | ext_sat;
				if (hcnt_q >= ((phase_q == PH_EXT16) ? Ext16Last : Ext64Last)) begin
					judge_bad = over_d || (len_d > max_payload);
					if (judge_bad) begin
						gen     = 1'b1;
						st      = ST_TOO_LARGE;
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_KEY;
						hcnt_d  = '0;
					end
				end else begin
					hcnt_d = hcnt_q + 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], data_byte};
				if (hcnt_q >= KeyLast) begin
					hcnt_d = '0;
					if (len_q == '0) begin
						gen     = 1'b1;
						st      = ST_EMPTY;
						plast   = 1'b1;
						phase_d = PH_SKIP;
					end else begin
						rem_d   = len_q;
						kidx_d  = '0;
						phase_d = PH_DATA;
					end
				end else begin
					hcnt_d = hcnt_q + 3'd1;
				end
			end
			PH_DATA: begin
				kidx_d = kidx_q + 2'd1;
				rem_d  = rem_q - {{(LenW-1){1'b0}}, 1'b1};
				if (rem_d == '0) begin
					gen     = 1'b1;
					st      = ST_DATA;
					pbyte   = data_byte ^ key_byte;
					plast   = 1'b1;
					phase_d = PH_SKIP;
				end else if (!end_of_buffer) begin
					gen   = 1'b1;
					st    = ST_DATA;
					pbyte = data_byte ^ key_byte;
				end
			end
			default: begin
			end
		endcase

		if (end_of_buffer) begin
			// A buffer that ends mid-frame reports incomplete unless this byte already spoke.
			if (!gen && phase_q != PH_SKIP) begin
				gen   = 1'b1;
				st    = ST_INCOMPLETE;
				pbyte = 8'd0;
				plast = 1'b0;
			end
			phase_d = PH_HDR0;
			hcnt_d  = '0;
		end
	end

	assign res_valid              = advance && gen;
	assign res.status             = st;
	assign res.payload_byte       = pbyte;
	assign res.last_of_payload    = plast;
	assign res.decoded_length     = len_d;
	assign res.frame_opcode       = opc_d;
	assign res.final_fragment     = fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			hcnt_q  <= '0;
			len_q   <= '0;
			over_q  <= 1'b0;
			key_q   <= '0;
			rem_q   <= '0;
			kidx_q  <= '0;
			opc_q   <= '0;
			fin_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			len_q   <= len_d;
			over_q  <= over_d;
			key_q   <= key_d;
			rem_q   <= rem_d;
			kidx_q  <= kidx_d;
			opc_q   <= opc_d;
			fin_q   <= fin_d;
		end
	end

endmodule

/* hdl/wsfp_out_reg.sv */
// ----------------------------------------------------------------------------
// wsfp_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module wsfp_out_reg
	import wsfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic         load,
	input  wsfp_result_t res_in,
	input  logic         out_ready,
	output logic         out_valid,
	output logic         free,
	output wsfp_result_t res_out
);

	logic         vld_q;
	wsfp_result_t res_q;

	// The register can take a new result when empty or being drained this cycle.
	assign free      = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= load;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

/* hdl/websocket_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// websocket_frame_parser_unit
// Byte-serial parser for client-to-server WebSocket frames with unmasking.
// ----------------------------------------------------------------------------
// Flow: a byte accepted into the input register is parsed combinationally and its
// result (if any) is loaded into the result register. Throughput: one byte per cycle
// while the result register has room; header and unmask logic is a single pass between the two registers.
// Reset: arst_n clears the parser to expect a first header byte, empties both
// registers and sets max_payload to 65536.
module websocket_frame_parser_unit
	import wsfp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	// Byte input channel.
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            end_of_buffer,
	// Result channel.
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [7:0]      payload_byte,
	output logic            last_of_payload,
	output logic [LenW-1:0] decoded_length,
	output logic [3:0]      frame_opcode,
	output logic            final_fragment,
	// Configuration write port for max_payload.
	input  logic            cfg_wr_en,
	input  logic [LenW-1:0] cfg_wr_data
);

	// Input register stage: holds one byte until the parser can consume it.
	logic            vld_s1;
	logic [7:0]      byte_s1;
	logic            eob_s1;
	logic [LenW-1:0] max_pay_q;

	logic            advance;
	logic            out_free;
	logic            res_valid;
	wsfp_result_t    res_core;
	wsfp_result_t    res_reg;

	// The parser consumes the staged byte whenever the result register has room,
	// so a held result never stops the byte stream as long as the consumer drains.
	assign advance  = vld_s1 && out_free;
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			max_pay_q <= MaxPayRst;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (cfg_wr_en) begin
				max_pay_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	// Header decoding, length checking and payload unmasking.
	wsfp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.data_byte     (byte_s1),
		.end_of_buffer (eob_s1),
		.max_payload   (max_pay_q),
		.res_valid     (res_valid),
		.res           (res_core)
	);

	// Result register toward the consumer.
	wsfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.load      (res_valid),
		.res_in    (res_core),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.res_out   (res_reg)
	);

	assign status          = res_reg.status;
	assign payload_byte    = res_reg.payload_byte;
	assign last_of_payload = res_reg.last_of_payload;
	assign decoded_length  = res_reg.decoded_length;
	assign frame_opcode    = res_reg.frame_opcode;
	assign final_fragment  = res_reg.final_fragment;

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-serial WebSocket frame parser. A short
// table of directed bytes comes first, then random frame buffers under several
// max_payload limits. Every accepted byte goes through an in-bench model of
// the parser, and the results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top
	import wsfp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// The watchdog gives up after this many cycles without a transaction.
	localparam int unsigned WatchdogLimit = 1000;
	// Idle cycles waited after the last owed result before reconfiguring.
	localparam int unsigned SettleCycles  = 8;
	localparam int unsigned PhaseBytes    = 120;
	localparam int unsigned DirectedRows  = 27;

	localparam wsfp_result_t NoResult = '0;

	// Parser phases of the in-bench model.
	typedef enum logic [2:0] {
		HDR_FIRST  = 3'd0,
		HDR_SECOND = 3'd1,
		LEN16      = 3'd2,
		LEN64      = 3'd3,
		KEY_BYTES  = 3'd4,
		PAYLOAD    = 3'd5,
		DISCARD    = 3'd6
	} parse_phase_t;

	// One directed byte. When typed is set, want holds the result that this
	// byte must produce, written out by hand; otherwise the model decides.
	typedef struct packed {
		logic [7:0]   octet;
		logic         eob;
		logic         typed;
		wsfp_result_t want;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [7:0]      data_byte;
	logic            end_of_buffer;
	logic            out_valid;
	logic            out_ready;
	logic [2:0]      status;
	logic [7:0]      payload_byte;
	logic            last_of_payload;
	logic [LenW-1:0] decoded_length;
	logic [3:0]      frame_opcode;
	logic            final_fragment;
	logic            cfg_wr_en;
	logic [LenW-1:0] cfg_wr_data;

	// Side information that travels with the byte on the input channel. It is
	// driven with the byte, so the monitor sees it at the accepting edge.
	logic            row_typed;
	wsfp_result_t    row_want;

	// Results still owed by the DUT, oldest first.
	wsfp_result_t    pending_results[$];
	int unsigned     mismatch_count = 0;
	int unsigned     idle_cycles = 0;

	// Idle pattern state of the byte sender and the result sink.
	bit              tx_burst = 1'b0;
	int unsigned     tx_left = 0;
	bit              rx_burst = 1'b0;
	int unsigned     rx_left = 0;

	// Model state, starting at the reset values of the parser.
	logic [LenW-1:0] limit_model = MaxPayRst;
	parse_phase_t    phase_q = HDR_FIRST;
	logic [2:0]      hdr_count = '0;
	logic [LenW-1:0] len_acc = '0;
	logic            len_over = 1'b0;
	logic [31:0]     mask_key = '0;
	logic [LenW-1:0] remaining = '0;
	logic [1:0]      key_idx = '0;
	logic [3:0]      opcode_q = '0;
	logic            fin_q = 1'b0;

	logic [LenW-1:0] limit_plan [8];

	// Directed bytes. They cover a buffer that ends on its first byte, an
	// unmasked frame, a 64-bit length that saturates and is rejected on the
	// very byte that ends the buffer (the error wins over "incomplete"), an
	// empty control frame followed by a trailing byte, and a one-byte masked
	// text frame whose only payload byte also ends the buffer.
	stim_row_t directed_rows [DirectedRows] = '{
		'{8'h00, 1'b1, 1'b1, '{ST_INCOMPLETE, 8'h00, 1'b0, 17'd0, 4'h0, 1'b0}},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'h7F, 1'b1, 1'b1, '{ST_UNMASKED, 8'h00, 1'b0, 17'd0, 4'hF, 1'b1}},
		'{8'h82, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b1, 1'b1, '{ST_TOO_LARGE, 8'h00, 1'b0, 17'h1FFFF, 4'h2, 1'b1}},
		'{8'h09, 1'b0, 1'b0, NoResult},
		'{8'h80, 1'b0, 1'b0, NoResult},
		'{8'h00, 1'b0, 1'b0, NoResult},
		'{8'hFF, 1'b0, 1'b0, NoResult},
		'{8'h12, 1'b0, 1'b0, NoResult},
		'{8'h34, 1'b0, 1'b1, '{ST_EMPTY, 8'h00, 1'b1, 17'd0, 4'h9, 1'b0}},
		'{8'hAB, 1'b1, 1'b0, NoResult},
		'{8'h81, 1'b0, 1'b0, NoResult},
		'{8'h81, 1'b0, 1'b0, NoResult},
		'{8'hA5, 1'b0, 1'b0, NoResult},
		'{8'h5A, 1'b0, 1'b0, NoResult},
		'{8'h0F, 1'b0, 1'b0, NoResult},
		'{8'hF0, 1'b0, 1'b0, NoResult},
		'{8'h3C, 1'b1, 1'b0, NoResult}
	};

	websocket_frame_parser_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.end_of_buffer   (end_of_buffer),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.payload_byte    (payload_byte),
		.last_of_payload (last_of_payload),
		.decoded_length  (decoded_length),
		.frame_opcode    (frame_opcode),
		.final_fragment  (final_fragment),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A result as the parser reports it from its current frame state.
	function automatic wsfp_result_t frame_result(input wsfp_status_t code,
			input logic [7:0] octet, input logic last);
		wsfp_result_t res;
		res.status          = code;
		res.payload_byte    = octet;
		res.last_of_payload = last;
		res.decoded_length  = len_acc;
		res.frame_opcode    = opcode_q;
		res.final_fragment  = fin_q;
		return res;
	endfunction

	function automatic string describe(input wsfp_result_t res);
		return $sformatf("status=%0d byte=%02h last=%0b len=%0d opcode=%0h fin=%0b",
			res.status, res.payload_byte, res.last_of_payload, res.decoded_length,
			res.frame_opcode, res.final_fragment);
	endfunction

	// Once the length is fully known, either reject the frame or move on to
	// the masking key.
	task automatic judge_frame_length(output bit produced, output wsfp_result_t res);
		produced = 1'b0;
		res = '0;
		if (len_over || len_acc > limit_model) begin
			res = frame_result(ST_TOO_LARGE, 8'h00, 1'b0);
			produced = 1'b1;
			phase_q = DISCARD;
		end else begin
			phase_q = KEY_BYTES;
			hdr_count = '0;
		end
	endtask

	// Advances the model by one byte and says whether that byte yields a result.
	task automatic parse_byte(input logic [7:0] octet, input logic eob,
			output bit produced, output wsfp_result_t res);
		parse_phase_t entry;
		logic [24:0]  widened;
		logic [2:0]   last_len_byte;
		logic [7:0]   key_byte;
		entry = phase_q;
		produced = 1'b0;
		res = '0;
		case (entry)
			HDR_FIRST: begin
				fin_q     = octet[7];
				opcode_q  = octet[3:0];
				len_acc   = '0;
				len_over  = 1'b0;
				hdr_count = '0;
				mask_key  = '0;
				key_idx   = '0;
				remaining = '0;
				phase_q   = HDR_SECOND;
			end
			HDR_SECOND: begin
				if (!octet[7]) begin
					// Client frames must be masked; drop the rest of the buffer.
					res = frame_result(ST_UNMASKED, 8'h00, 1'b0);
					produced = 1'b1;
					phase_q = DISCARD;
				end else begin
					hdr_count = '0;
					if (octet[6:0] == Len7Ext16) begin
						phase_q = LEN16;
					end else if (octet[6:0] == Len7Ext64) begin
						phase_q = LEN64;
					end else begin
						len_acc = {10'd0, octet[6:0]};
						judge_frame_length(produced, res);
					end
				end
			end
			LEN16, LEN64: begin
				// Extended lengths shift in big-endian and saturate at the
				// 17-bit ceiling, which also marks the frame as too long.
				widened = {len_acc, octet};
				last_len_byte = (entry == LEN16) ? Ext16Last : Ext64Last;
				if (widened > LenSat) begin
					len_acc  = LenSat;
					len_over = 1'b1;
				end else begin
					len_acc = widened[LenW-1:0];
				end
				if (hdr_count >= last_len_byte) begin
					judge_frame_length(produced, res);
				end else begin
					hdr_count = hdr_count + 3'd1;
				end
			end
			KEY_BYTES: begin
				mask_key = {mask_key[23:0], octet};
				if (hdr_count >= KeyLast) begin
					hdr_count = '0;
					if (len_acc == '0) begin
						res = frame_result(ST_EMPTY, 8'h00, 1'b1);
						produced = 1'b1;
						phase_q = DISCARD;
					end else begin
						remaining = len_acc;
						key_idx = '0;
						phase_q = PAYLOAD;
					end
				end else begin
					hdr_count = hdr_count + 3'd1;
				end
			end
			PAYLOAD: begin
				// The first key byte received unmasks payload byte 0.
				key_byte = mask_key[8 * (3 - int'(key_idx)) +: 8];
				key_idx = key_idx + 2'd1;
				remaining = remaining - 17'd1;
				if (remaining == '0) begin
					res = frame_result(ST_DATA, octet ^ key_byte, 1'b1);
					produced = 1'b1;
					phase_q = DISCARD;
				end else if (!eob) begin
					res = frame_result(ST_DATA, octet ^ key_byte, 1'b0);
					produced = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// A buffer that stops short reports "incomplete", unless this byte
		// already produced a verdict or the frame was finished before.
		if (eob) begin
			if (!produced && entry != DISCARD) begin
				res = frame_result(ST_INCOMPLETE, 8'h00, 1'b0);
				produced = 1'b1;
			end
			phase_q = HDR_FIRST;
			hdr_count = '0;
		end
	endtask

	// Idle cycles before the next transaction on one side. Runs of
	// back-to-back transactions are mixed with runs of random idling.
	function automatic int unsigned draw_wait(inout bit burst, inout int unsigned left);
		if (left == 0) begin
			burst = ($urandom_range(0, 3) == 0);
			left = $urandom_range(8, 40);
		end
		left--;
		return burst ? 0 : $urandom_range(0, 9);
	endfunction

	// Presents one byte and returns at the edge where it is accepted. Valid
	// stays high into the next byte when no idle cycles are drawn.
	task automatic send_byte(input logic [7:0] octet, input logic eob,
			input logic typed, input wsfp_result_t want);
		int unsigned gap;
		gap = draw_wait(tx_burst, tx_left);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= octet;
		end_of_buffer <= eob;
		row_typed     <= typed;
		row_want      <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stops sending and waits until the DUT owes nothing and has gone quiet.
	// The first edge lets the monitor record the last accepted byte.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// One random receive buffer. Most are masked frames of random content with
	// a length near the current limit, small enough to send in full or random; the
	// rest are unmasked frames and plain noise. Buffers may stop anywhere, and
	// finished frames may carry trailing bytes.
	task automatic send_random_buffer(inout int unsigned counted);
		logic [7:0]  octets[$];
		logic [63:0] frame_len;
		logic [6:0]  len_code;
		int          near_len;
		int unsigned pick;
		int unsigned keep;
		int unsigned n_payload;
		pick = $urandom_range(0, 99);
		near_len = int'(limit_model) + int'($urandom_range(0, 4)) - 2;
		if (near_len < 0) begin
			near_len = 0;
		end
		if (pick < 12) begin
			repeat ($urandom_range(1, 10)) octets.push_back(8'($urandom));
			keep = octets.size();
		end else begin
			octets.push_back(8'($urandom));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					frame_len = 64'($urandom_range(0, 12));
					len_code = frame_len[6:0];
				end
				5: begin
					frame_len = 64'($urandom_range(0, 125));
					len_code = frame_len[6:0];
				end
				6: begin
					frame_len = (near_len > 65535) ? 64'd65535 : 64'(near_len);
					len_code = Len7Ext16;
				end
				7: begin
					frame_len = $urandom_range(0, 1) ? 64'($urandom_range(0, 40))
						: 64'($urandom_range(0, 65535));
					len_code = Len7Ext16;
				end
				8: begin
					frame_len = {$urandom, $urandom};
					len_code = Len7Ext64;
				end
				default: begin
					frame_len = $urandom_range(0, 1) ? 64'(near_len)
						: 64'($urandom_range(0, 40));
					len_code = Len7Ext64;
				end
			endcase
			// About one frame in eight omits the mask bit.
			octets.push_back({(pick >= 24), len_code});
			if (len_code == Len7Ext16) begin
				octets.push_back(frame_len[15:8]);
				octets.push_back(frame_len[7:0]);
			end else if (len_code == Len7Ext64) begin
				for (int i = 7; i >= 0; i--) octets.push_back(frame_len[8*i +: 8]);
			end
			repeat (4) octets.push_back(8'($urandom));
			n_payload = (frame_len <= 64'd48) ? int'(frame_len) : $urandom_range(0, 20);
			repeat (n_payload) octets.push_back(8'($urandom));
			if (frame_len <= 64'd48 && $urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(0, 3)) octets.push_back(8'($urandom));
				keep = octets.size();
			end else begin
				keep = $urandom_range(1, octets.size());
			end
		end
		for (int i = 0; i < keep; i++) begin
			send_byte(octets[i], (i == keep - 1), 1'b0, NoResult);
		end
		counted += keep;
	endtask

	// Monitor: models every accepted byte and checks every accepted result.
	always @(posedge clk) begin : result_monitor
		wsfp_result_t predicted;
		wsfp_result_t observed;
		wsfp_result_t oldest;
		bit           produced;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_byte(data_byte, end_of_buffer, produced, predicted);
				if (row_typed) begin
					pending_results.push_back(row_want);
				end else if (produced) begin
					pending_results.push_back(predicted);
				end
			end
			if (out_valid && out_ready) begin
				observed.status          = wsfp_status_t'(status);
				observed.payload_byte    = payload_byte;
				observed.last_of_payload = last_of_payload;
				observed.decoded_length  = decoded_length;
				observed.frame_opcode    = frame_opcode;
				observed.final_fragment  = final_fragment;
				if (pending_results.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("%0t: result with nothing expected: %s", $time,
							describe(observed));
					end
					mismatch_count++;
				end else begin
					oldest = pending_results.pop_front();
					if (observed.status != oldest.status
							|| observed.payload_byte != oldest.payload_byte
							|| observed.last_of_payload != oldest.last_of_payload
							|| observed.decoded_length != oldest.decoded_length
							|| observed.frame_opcode != oldest.frame_opcode
							|| observed.final_fragment != oldest.final_fragment) begin
						if (mismatch_count < 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", describe(oldest));
							$display("  actual   %s", describe(observed));
						end
						mismatch_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	// Result sink: a random stall, or none during a burst, before each transaction.
	initial begin : result_sink
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = draw_wait(rx_burst, rx_left);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		while (idle_cycles < WatchdogLimit) @(posedge clk);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase_bytes;
		in_valid      = 1'b0;
		data_byte     = '0;
		end_of_buffer = 1'b0;
		row_typed     = 1'b0;
		row_want      = NoResult;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed table runs with the reset limit of 65536.
		for (int i = 0; i < DirectedRows; i++) begin
			send_byte(directed_rows[i].octet, directed_rows[i].eob,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Limits for the random phases: both ends of the range, the values
		// around the 7-bit length codes, and two random ones.
		limit_plan = '{17'd0, 17'd125, 17'd126, 17'd65535, 17'd1,
			17'($urandom_range(2, 65534)), MaxPayRst, 17'($urandom_range(127, 4000))};

		// Each phase starts from an idle DUT: the sender holds off until every
		// owed result has come out, then the new limit is written.
		for (int p = 0; p < 8; p++) begin
			wait_for_idle();
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= limit_plan[p];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			limit_model = limit_plan[p];
			phase_bytes = 0;
			while (phase_bytes < PhaseBytes) send_random_buffer(phase_bytes);
		end

		wait_for_idle();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
